// ===== rtl/accl_pkg.sv =====
`default_nettype none

package accl_pkg;

  // Item kinds carried in the kind field.
  typedef enum logic [1:0] {
    KIND_STATS = 2'd0,
    KIND_PIN   = 2'd1,
    KIND_UNPIN = 2'd2,
    KIND_TAKE  = 2'd3
  } kind_t;

  // Register indexes on the configuration port (byte address is 8 times the index).
  localparam logic [1:0] REG_MEM_LIMIT = 2'd0;
  localparam logic [1:0] REG_MAX_CAP   = 2'd1;
  localparam logic [1:0] REG_ROWS      = 2'd2;

  localparam int ADDR_W  = 5;
  localparam int PDATA_W = 64;

  localparam logic [47:0] MEM_LIMIT_RST = 48'd268435456;
  localparam logic [15:0] MAX_CAP_RST   = 16'd64;
  localparam logic [15:0] ROWS_RST      = 16'd4096;

  // Shared serial divider.
  localparam int          DIV_W     = 64;
  localparam int          STEP_W    = 7;
  localparam logic [6:0]  STEPS_AVG = 7'd64;
  localparam logic [6:0]  STEPS_CAP = 7'd48;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV1,
    ST_QUOT,
    ST_MUL,
    ST_DIV2S,
    ST_DIV2,
    ST_CLAMP
  } state_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

// ===== rtl/accl_if.sv =====
`default_nettype none

interface accl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] added_bytes;
  logic [23:0] added_rows;
  logic [15:0] chunk_count;

  modport source(output valid, kind, added_bytes, added_rows, chunk_count, input ready);
  modport sink(input valid, kind, added_bytes, added_rows, chunk_count, output ready);
endinterface

interface accl_out_if;
  logic        valid;
  logic        ready;
  logic        granted;
  logic [15:0] capacity_now;
  logic [16:0] pinned_now;
  logic        full_event;
  logic        underflow;

  modport source(output valid, granted, capacity_now, pinned_now, full_event, underflow,
                 input ready);
  modport sink(input valid, granted, capacity_now, pinned_now, full_event, underflow,
               output ready);
endinterface

`default_nettype wire

// ===== rtl/accl_div.sv =====
`default_nettype none

module accl_div (
  input  logic                          clk,
  input  logic                          rst,
  input  accl_pkg::div_ctl_t            ctl,
  input  logic [accl_pkg::DIV_W-1:0]    dividend,
  input  logic [accl_pkg::DIV_W-1:0]    divisor,
  output accl_pkg::div_sts_t            sts,
  output logic [accl_pkg::DIV_W-1:0]    quotient
);
  import accl_pkg::*;

  logic [DIV_W:0]    rem;
  logic [DIV_W-1:0]  quo;
  logic [DIV_W-1:0]  dsr;
  logic [STEP_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    diff;
  logic              ge;

  // Restoring division, one quotient bit per cycle. The dividend shifts out
  // of the top of quo while quotient bits shift in at the bottom.
  assign shifted = {rem[DIV_W-1:0], quo[DIV_W-1]};
  assign ge      = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
        cnt  <= ctl.steps;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff : shifted;
        quo <= {quo[DIV_W-2:0], ge};
        cnt <= cnt - STEP_W'(1);
        if (cnt == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign quotient = quo;

endmodule

`default_nettype wire

// ===== rtl/adaptive_chunk_credit_limiter.sv =====
// Chunk credit limiter. Items arrive on the cmd channel and each one yields
// exactly one result item on the res channel; both use valid/ready and an
// item moves at a clock edge where valid and ready are both high.
// Pin, unpin and take items are handled at the edge that accepts them and
// their result is valid in the next cycle. A stats item updates the running
// byte and row totals and then recomputes the capacity: a 64-step bit-serial
// division for the average row size, a 16-step shift-add multiply by
// rows_per_chunk, and a 48-step division of the memory limit by the usage,
// both divisions sharing one serial divider. A stats item ends early while
// the row total is zero, and after the first division when the average or
// rows_per_chunk is zero; only the latter sets the capacity to the maximum.
// One item is in work at a time; the next is accepted once the block is idle
// and the result register is free or being emptied in that same cycle.
// When the receiver stalls, the result holds in the output register and no
// new item is taken until it leaves. Reset (rst, synchronous) loads the
// registers with their default values, clears the totals, the pinned count
// and the pending event, and sets the capacity to the default maximum. The
// registers are written over the APB port at byte addresses 0, 8 and 16;
// the user writes them only while the block is idle, which it does not enforce.
`default_nettype none

module adaptive_chunk_credit_limiter (
  input  logic                            clk,
  input  logic                            rst,
  accl_in_if.sink                         cmd,
  accl_out_if.source                      res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [accl_pkg::ADDR_W-1:0]     paddr,
  input  logic [accl_pkg::PDATA_W-1:0]    pwdata,
  output logic [accl_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import accl_pkg::*;

  // Configuration registers.
  logic [47:0] mem_limit;
  logic [15:0] max_cap;
  logic [15:0] rows_per_chunk;

  // Limiter state.
  logic [63:0] byte_total;
  logic [63:0] row_total;
  logic [15:0] capacity;
  logic [16:0] pinned;
  logic        ev_pend;

  // Stats datapath.
  state_t      state;
  state_t      state_next;
  logic [63:0] avg;
  logic [79:0] acc;
  logic [3:0]  mcnt;

  // Result register.
  logic        ov;
  logic        o_granted;
  logic [15:0] o_capacity;
  logic [16:0] o_pinned;
  logic        o_full;
  logic        o_under;

  div_ctl_t    div_ctl;
  div_sts_t    div_sts;
  logic [63:0] div_dividend;
  logic [63:0] div_quot;

  logic        out_free;
  logic        accept;
  logic        fast_load;
  logic        done_load;
  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  kind_t       kind;

  logic [64:0] byte_sum;
  logic [64:0] row_sum;
  logic [63:0] usage;
  logic [17:0] pin_sum;
  logic        pin_ok;
  logic        unpin_under;
  logic [16:0] pinned_upd;
  logic        ev_upd;
  logic        granted_upd;
  logic [63:0] cap_lo;
  logic [15:0] cap_clamped;

  // Outputs of the control.
  logic        stats_done;
  logic        stats_wait;

  assign pready   = 1'b1;
  assign cfg_idx  = paddr[4:3];
  assign cfg_wr   = psel && penable && pwrite;
  assign kind     = kind_t'(cmd.kind);
  assign out_free = !ov || res.ready;
  assign accept   = cmd.valid && cmd.ready;

  always_comb begin
    unique case (cfg_idx)
      REG_MEM_LIMIT: prdata = {16'h0, mem_limit};
      REG_MAX_CAP:   prdata = {48'h0, max_cap};
      REG_ROWS:      prdata = {48'h0, rows_per_chunk};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_limit      <= MEM_LIMIT_RST;
      max_cap        <= MAX_CAP_RST;
      rows_per_chunk <= ROWS_RST;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_MEM_LIMIT) begin
        mem_limit <= pwdata[47:0];
      end
      if (cfg_idx == REG_MAX_CAP) begin
        max_cap <= pwdata[15:0];
      end
      if (cfg_idx == REG_ROWS) begin
        rows_per_chunk <= pwdata[15:0];
      end
    end
  end

  // Saturating totals.
  assign byte_sum = {1'b0, byte_total} + {33'h0, cmd.added_bytes};
  assign row_sum  = {1'b0, row_total} + {41'h0, cmd.added_rows};

  // Pin and unpin decisions for the kinds handled at acceptance.
  assign pin_sum     = {1'b0, pinned} + {2'b0, cmd.chunk_count};
  assign pin_ok      = pin_sum <= {2'b0, capacity};
  assign unpin_under = {1'b0, cmd.chunk_count} > pinned;

  always_comb begin
    pinned_upd  = pinned;
    ev_upd      = ev_pend;
    granted_upd = 1'b0;
    unique case (kind)
      KIND_PIN: begin
        if (pin_ok) begin
          pinned_upd  = pin_sum[16:0];
          granted_upd = 1'b1;
        end else if (pinned < {1'b0, capacity}) begin
          // A refused pin below capacity still raises the event.
          ev_upd = 1'b1;
        end
      end
      KIND_UNPIN: begin
        pinned_upd = unpin_under ? '0 : pinned - {1'b0, cmd.chunk_count};
        if (pinned >= {1'b0, capacity} && pinned_upd < {1'b0, capacity}) begin
          ev_upd = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // The multiply result saturates at the top of the 64-bit range.
  assign usage = (|acc[79:64]) ? '1 : acc[63:0];

  // Clamp order: at least one, then at most the maximum.
  assign cap_lo      = (div_quot == '0) ? 64'd1 : div_quot;
  assign cap_clamped = (cap_lo > {48'h0, max_cap}) ? max_cap : cap_lo[15:0];

  // Next state. A finished stats item returns to idle at once; its result
  // waits for the output register under the stats_wait flag.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && kind == KIND_STATS) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: state_next = (row_total == '0) ? ST_IDLE : ST_DIV1;
      ST_DIV1: begin
        if (div_sts.done) begin
          state_next = ST_QUOT;
        end
      end
      ST_QUOT: begin
        if (avg == '0 || rows_per_chunk == '0) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mcnt == '0) begin
          state_next = ST_DIV2S;
        end
      end
      ST_DIV2S: state_next = ST_DIV2;
      ST_DIV2: begin
        if (div_sts.done) begin
          state_next = ST_CLAMP;
        end
      end
      ST_CLAMP: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    div_ctl       = '0;
    div_dividend  = byte_total;
    stats_done    = 1'b0;
    unique case (state)
      ST_CHECK: begin
        if (row_total != '0) begin
          div_ctl.start = 1'b1;
          div_ctl.steps = STEPS_AVG;
        end else begin
          stats_done = 1'b1;
        end
      end
      ST_QUOT: begin
        stats_done = (avg == '0) || (rows_per_chunk == '0);
      end
      ST_DIV2S: begin
        div_ctl.start = 1'b1;
        div_ctl.steps = STEPS_CAP;
        div_dividend  = {mem_limit, 16'h0};
      end
      ST_CLAMP: stats_done = 1'b1;
      default: begin
      end
    endcase
  end

  // Items are taken only when idle, with no finished stats result waiting,
  // and with room in the result register.
  assign cmd.ready = (state == ST_IDLE) && !stats_wait && out_free;
  assign fast_load = accept && kind != KIND_STATS;
  assign done_load = stats_wait && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      stats_wait <= 1'b0;
      byte_total <= '0;
      row_total  <= '0;
      capacity   <= MAX_CAP_RST;
      pinned     <= '0;
      ev_pend    <= 1'b0;
    end else begin
      state <= state_next;
      if (stats_done) begin
        stats_wait <= 1'b1;
      end else if (done_load) begin
        stats_wait <= 1'b0;
      end
      if (accept) begin
        if (kind == KIND_STATS) begin
          byte_total <= byte_sum[64] ? '1 : byte_sum[63:0];
          row_total  <= row_sum[64] ? '1 : row_sum[63:0];
        end else begin
          pinned  <= pinned_upd;
          ev_pend <= (kind == KIND_TAKE) ? 1'b0 : ev_upd;
        end
      end
      if (state == ST_QUOT && avg != '0 && rows_per_chunk == '0) begin
        capacity <= max_cap;
      end
      if (state == ST_CLAMP) begin
        capacity <= cap_clamped;
      end
    end
  end

  // Serial multiply, most significant bit of rows_per_chunk first.
  always_ff @(posedge clk) begin
    if (state == ST_DIV1 && div_sts.done) begin
      avg <= div_quot;
    end
    if (state == ST_QUOT) begin
      acc  <= '0;
      mcnt <= 4'd15;
    end else if (state == ST_MUL) begin
      acc  <= {acc[78:0], 1'b0} + (rows_per_chunk[mcnt] ? {16'h0, avg} : 80'h0);
      mcnt <= mcnt - 4'd1;
    end
  end

  accl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  ((state == ST_DIV2S) ? usage : row_total),
    .sts      (div_sts),
    .quotient (div_quot)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (fast_load || done_load) begin
      ov <= 1'b1;
    end else if (res.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fast_load) begin
      o_granted  <= granted_upd;
      o_capacity <= capacity;
      o_pinned   <= pinned_upd;
      o_full     <= ev_upd;
      o_under    <= (kind == KIND_UNPIN) && unpin_under;
    end else if (done_load) begin
      o_granted  <= 1'b0;
      o_capacity <= capacity;
      o_pinned   <= pinned;
      o_full     <= ev_pend;
      o_under    <= 1'b0;
    end
  end

  assign res.valid        = ov;
  assign res.granted      = o_granted;
  assign res.capacity_now = o_capacity;
  assign res.pinned_now   = o_pinned;
  assign res.full_event   = o_full;
  assign res.underflow    = o_under;

endmodule

`default_nettype wire

// ===== rtl/accl_checker.sv =====
`default_nettype none

module accl_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        granted,
  input logic [15:0] capacity_now,
  input logic [16:0] pinned_now,
  input logic        full_event,
  input logic        underflow
);

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(granted) && $stable(capacity_now)
      && $stable(pinned_now) && $stable(full_event) && $stable(underflow))
    else $error("result changed while stalled");

  // A granted pin never leaves the count above the capacity.
  a_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && granted |-> {1'b0, capacity_now} >= pinned_now)
    else $error("grant exceeds capacity");

  // An underflowing unpin clears the count and grants nothing.
  a_under: assert property (@(posedge clk) disable iff (rst)
    out_valid && underflow |-> pinned_now == 17'd0 && !granted)
    else $error("underflow with nonzero count");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // No item is taken while the result register is full and stalled.
  a_noacc: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !(in_valid && in_ready))
    else $error("item accepted with no room for its result");

endmodule

bind adaptive_chunk_credit_limiter accl_checker u_accl_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (cmd.valid),
  .in_ready     (cmd.ready),
  .out_valid    (res.valid),
  .out_ready    (res.ready),
  .granted      (res.granted),
  .capacity_now (res.capacity_now),
  .pinned_now   (res.pinned_now),
  .full_event   (res.full_event),
  .underflow    (res.underflow)
);

`default_nettype wire

// ===== test/accl_credit_checker.sv =====
`timescale 1ns / 100ps

// Watches the item channels and the register port, predicts every result
// from its own copy of the limiter state and compares in order.
module accl_credit_checker (
  input  logic                         clk,
  input  logic                         rst,
  accl_in_if                           cmd,
  accl_out_if                          res,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [accl_pkg::ADDR_W-1:0]  paddr,
  input  logic [accl_pkg::PDATA_W-1:0] pwdata,
  input  logic [accl_pkg::PDATA_W-1:0] prdata,
  input  logic                         pready,
  output int                           fail_count
);
  import accl_pkg::*;

  typedef struct packed {
    logic        granted;
    logic [15:0] capacity_now;
    logic [16:0] pinned_now;
    logic        full_event;
    logic        underflow;
  } credit_result_t;

  logic [47:0]    mem_limit;
  logic [15:0]    max_cap;
  logic [15:0]    rows_per_chunk;
  logic [63:0]    byte_total;
  logic [63:0]    row_total;
  logic [15:0]    capacity;
  logic [16:0]    pinned;
  logic           event_pending;
  credit_result_t expected_results[$];
  credit_result_t oldest;
  logic [1:0]     reg_idx;
  logic [63:0]    reg_value;
  int             result_index;

  function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
    logic [64:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[64] ? '1 : sum[63:0];
  endfunction

  // Applies one item to the shadow state and returns the result it yields.
  function automatic credit_result_t credit_after_item(kind_t kind, logic [31:0] bytes,
                                                       logic [23:0] rows, logic [15:0] count);
    credit_result_t r;
    logic [63:0]    avg;
    logic [63:0]    usage;
    logic [63:0]    quot;
    logic [127:0]   prod;
    logic [16:0]    prev;
    r = '0;
    case (kind)
      KIND_STATS: begin
        byte_total = add_clamped(byte_total, {32'd0, bytes});
        row_total  = add_clamped(row_total, {40'd0, rows});
        avg = (row_total != 0) ? byte_total / row_total : 64'd0;
        if (avg != 0) begin
          if (rows_per_chunk == 0) begin
            capacity = max_cap;
          end else begin
            prod  = {64'd0, avg} * {112'd0, rows_per_chunk};
            usage = (prod[127:64] != 0) ? '1 : prod[63:0];
            quot  = {16'd0, mem_limit} / usage;
            if (quot < 1) quot = 1;
            if (quot > {48'd0, max_cap}) quot = {48'd0, max_cap};
            capacity = quot[15:0];
          end
        end
      end
      KIND_PIN: begin
        if ({1'b0, pinned} + {2'b0, count} > {2'b0, capacity}) begin
          // A refused pin still flags the event while below capacity.
          if (pinned < {1'b0, capacity}) event_pending = 1'b1;
        end else begin
          pinned    = pinned + {1'b0, count};
          r.granted = 1'b1;
        end
      end
      KIND_UNPIN: begin
        prev = pinned;
        if ({1'b0, count} > pinned) begin
          pinned      = '0;
          r.underflow = 1'b1;
        end else begin
          pinned = pinned - {1'b0, count};
        end
        if (prev >= {1'b0, capacity} && pinned < {1'b0, capacity}) event_pending = 1'b1;
      end
      default: ;
    endcase
    r.capacity_now = capacity;
    r.pinned_now   = pinned;
    r.full_event   = event_pending;
    if (kind == KIND_TAKE) event_pending = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    fail_count++;
    if (fail_count <= 100)
      $display("%0t: mismatch on %s at result %0d: expected %0h, got %0h",
               $time, what, result_index, want, got);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mem_limit      = MEM_LIMIT_RST;
      max_cap        = MAX_CAP_RST;
      rows_per_chunk = ROWS_RST;
      byte_total     = '0;
      row_total      = '0;
      capacity       = MAX_CAP_RST;
      pinned         = '0;
      event_pending  = 1'b0;
      result_index   = 0;
      fail_count     = 0;
      expected_results.delete();
    end else begin
      if (psel && penable && pready) begin
        reg_idx = paddr[4:3];
        if (pwrite) begin
          case (reg_idx)
            REG_MEM_LIMIT: mem_limit = pwdata[47:0];
            REG_MAX_CAP:   max_cap = pwdata[15:0];
            REG_ROWS:      rows_per_chunk = pwdata[15:0];
            default: ;
          endcase
        end else begin
          case (reg_idx)
            REG_MEM_LIMIT: reg_value = {16'd0, mem_limit};
            REG_MAX_CAP:   reg_value = {48'd0, max_cap};
            default:       reg_value = {48'd0, rows_per_chunk};
          endcase
          if (prdata !== reg_value) report_mismatch("register read", reg_value, prdata);
        end
      end

      // Results are matched before new items are queued, since a result
      // leaving at this edge can never belong to an item entering at it.
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", '0, '0);
        end else begin
          oldest = expected_results.pop_front();
          if (res.granted !== oldest.granted)
            report_mismatch("granted", 64'(oldest.granted), 64'(res.granted));
          if (res.capacity_now !== oldest.capacity_now)
            report_mismatch("capacity_now", 64'(oldest.capacity_now),
                            64'(res.capacity_now));
          if (res.pinned_now !== oldest.pinned_now)
            report_mismatch("pinned_now", 64'(oldest.pinned_now), 64'(res.pinned_now));
          if (res.full_event !== oldest.full_event)
            report_mismatch("full_event", 64'(oldest.full_event), 64'(res.full_event));
          if (res.underflow !== oldest.underflow)
            report_mismatch("underflow", 64'(oldest.underflow), 64'(res.underflow));
        end
        result_index++;
      end

      if (cmd.valid && cmd.ready)
        expected_results.push_back(credit_after_item(kind_t'(cmd.kind), cmd.added_bytes,
                                                     cmd.added_rows, cmd.chunk_count));
    end
  end

endmodule

// ===== test/tb_adaptive_chunk_credit_limiter.sv =====
`timescale 1ns / 100ps

// Top of the limiter testbench. This module only makes stimulus and gives the
// verdict; the checker beside the block predicts and compares every result.
module tb_adaptive_chunk_credit_limiter;
  import accl_pkg::*;

  // The limit leaves room for every item being a stats item that also waits
  // out long receiver and sender gaps.
  localparam int CYCLE_LIMIT = 1_000_000;
  // Length of the long receiver hold-off, in cycles.
  localparam int HOLD_CYCLES = 400;
  // Cycles allowed after the last result, a little above the stats latency.
  localparam int TAIL_CYCLES = 150;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  int                 fail_count;
  int                 items_taken;
  int                 results_taken;
  int                 snd_idle;
  int                 rcv_idle;
  int                 hold_ticket;

  accl_in_if  cmd_ch ();
  accl_out_if res_ch ();

  adaptive_chunk_credit_limiter dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  accl_credit_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Every item yields exactly one result, so the block is idle with nothing
  // owed whenever these two counts agree.
  always @(posedge clk) begin
    if (rst) begin
      items_taken   <= 0;
      results_taken <= 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) items_taken <= items_taken + 1;
      if (res_ch.valid && res_ch.ready) results_taken <= results_taken + 1;
    end
  end

  // Receiver. It stalls at random at the current idle rate, and whenever the
  // stimulus bumps the hold ticket it refuses results for a long stretch so
  // that the block backs up and stops taking items.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  // Offers one item after a random gap and returns at the edge that takes
  // it. Valid stays high so back-to-back items go without a gap in valid.
  task automatic send_item(kind_t kind, logic [31:0] bytes, logic [23:0] rows,
                           logic [15:0] count);
    while ($urandom_range(99) < snd_idle) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.kind        <= kind;
    cmd_ch.added_bytes <= bytes;
    cmd_ch.added_rows  <= rows;
    cmd_ch.chunk_count <= count;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Most items are small requests that keep the pinned count hovering around
  // the capacity, so grants, refusals and the full event all happen often.
  // About one in sixteen carries fully random fields instead, which also
  // brings huge pins and unpins that underflow.
  task automatic send_random_item();
    int          pick;
    kind_t       kind;
    logic [31:0] bytes;
    logic [23:0] rows;
    logic [15:0] count;
    pick = $urandom_range(99);
    kind = (pick < 17) ? KIND_STATS : (pick < 57) ? KIND_PIN :
           (pick < 85) ? KIND_UNPIN : KIND_TAKE;
    if ($urandom_range(15) == 0) begin
      bytes = $urandom;
      rows  = 24'($urandom);
      count = 16'($urandom);
    end else begin
      rows  = 24'($urandom_range(1, 64));
      bytes = rows * $urandom_range(1, 4000);
      count = 16'($urandom_range(0, 6));
    end
    send_item(kind, bytes, rows, count);
  endtask

  // Stops offering and waits until every item has its result back.
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (items_taken != results_taken);
  endtask

  // One register access: a setup cycle, an access cycle, then a cycle with
  // the port deselected so that accesses never overlap.
  task automatic apb_access(logic wr, logic [1:0] idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // The checker compares every read against its own register copy.
  task automatic read_all_regs();
    for (int i = REG_MEM_LIMIT; i <= REG_ROWS; i++) apb_access(1'b0, 2'(i), '0);
  endtask

  // Only called while the block is idle with no result owed.
  task automatic set_limits(logic [47:0] mem_limit, logic [15:0] max_cap,
                            logic [15:0] rows_per_chunk);
    apb_access(1'b1, REG_MEM_LIMIT, {16'd0, mem_limit});
    apb_access(1'b1, REG_MAX_CAP, {48'd0, max_cap});
    apb_access(1'b1, REG_ROWS, {48'd0, rows_per_chunk});
    read_all_regs();
  endtask

  initial begin
    cmd_ch.valid       <= 1'b0;
    cmd_ch.kind        <= KIND_STATS;
    cmd_ch.added_bytes <= '0;
    cmd_ch.added_rows  <= '0;
    cmd_ch.chunk_count <= '0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    rst                <= 1'b1;
    rcv_idle           <= 0;
    hold_ticket        <= 0;
    snd_idle = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The registers must read back their defaults straight after reset.
    read_all_regs();

    // Directed part, starting from the default capacity.
    send_item(KIND_TAKE, '0, '0, '0);            // Nothing pending yet.
    send_item(KIND_PIN, '0, '0, 16'd0);           // An empty pin is granted.
    send_item(KIND_PIN, '0, '0, MAX_CAP_RST);     // Fill exactly to capacity.
    send_item(KIND_PIN, '0, '0, 16'd1);           // Refused at full, no event.
    send_item(KIND_UNPIN, '0, '0, 16'd1);         // Leaving full raises the event.
    send_item(KIND_TAKE, '0, '0, '0);             // Reports it and clears it.
    // A refused pin below capacity raises the event too. The stats fields
    // are all ones here to show that a pin ignores them.
    send_item(KIND_PIN, '1, '1, 16'd5);
    send_item(KIND_TAKE, '0, '0, '0);
    send_item(KIND_UNPIN, '0, '0, 16'hFFFF);      // Underflow clamps to zero.
    // With no rows counted yet the capacity cannot move.
    send_item(KIND_STATS, '0, '0, '1);
    // A zero average leaves the capacity alone as well.
    send_item(KIND_STATS, '0, '1, '0);
    wait_drained();

    // With zero rows per chunk the capacity follows the maximum, and a zero
    // maximum gives a capacity of zero where only empty pins can pass.
    set_limits(MEM_LIMIT_RST, 16'd0, 16'd0);
    send_item(KIND_STATS, '1, '0, '0);
    send_item(KIND_PIN, '0, '0, 16'd0);
    send_item(KIND_PIN, '0, '0, 16'd1);
    wait_drained();

    // No memory at all: the quotient is zero and the capacity floors at one.
    set_limits('0, 16'hFFFF, 16'hFFFF);
    send_item(KIND_STATS, '0, '0, '0);
    send_item(KIND_PIN, '0, '0, 16'd2);
    send_item(KIND_TAKE, '0, '0, '0);
    wait_drained();

    // All memory and one row per chunk: the capacity clamps at the top and
    // the pinned count can reach its largest value.
    set_limits('1, 16'hFFFF, 16'd1);
    send_item(KIND_STATS, '0, '0, '0);
    send_item(KIND_PIN, '0, '0, 16'hFFFF);
    send_item(KIND_PIN, '0, '0, 16'd1);
    send_item(KIND_UNPIN, '0, '0, 16'd0);
    send_item(KIND_UNPIN, '0, '0, 16'hFFFF);
    send_item(KIND_TAKE, '0, '0, '0);
    wait_drained();

    // Random part, first with a rarely idle sender and a mostly stalled
    // receiver, and a capacity a little below fifty.
    snd_idle = 9;
    rcv_idle <= 87;
    set_limits(48'd2097152, 16'd48, 16'd64);
    repeat (480) send_random_item();
    wait_drained();

    // Then the other way round, with a wide maximum so the computed value
    // decides the capacity. Halfway through, the sender pauses until every
    // result is back.
    snd_idle = 87;
    rcv_idle <= 9;
    set_limits(48'd800000 + 48'($urandom_range(0, 400000)), 16'hFFFF,
               16'($urandom_range(16, 256)));
    repeat (240) send_random_item();
    wait_drained();
    repeat (240) send_random_item();
    wait_drained();

    // Finally neither side idles on its own. The receiver starts with a long
    // hold-off while items keep coming, so the block fills and stalls.
    snd_idle = 0;
    rcv_idle <= 0;
    set_limits('1, 16'd20, 16'hFFFF);
    hold_ticket <= hold_ticket + 1;
    repeat (460) send_random_item();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/accl_pkg.sv
rtl/accl_if.sv
rtl/accl_div.sv
rtl/adaptive_chunk_credit_limiter.sv
rtl/accl_checker.sv
test/accl_credit_checker.sv
test/tb_adaptive_chunk_credit_limiter.sv
